### hdl/assert_macros.svh
// Assertion macros used by the curve rasteriser sequencer (hbc_ctrl).
// Both expect signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HBC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("hbc assertion failed");
`define HBC_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |=> (post)) else $error("hbc assertion failed");
`else
`define HBC_ASSERT(lbl, prop)
`define HBC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### hdl/hbc_pkg.sv
// ----------------------------------------------------------------------------
// hbc_pkg
// Widths, register indexes and command types of the curve rasteriser.
// ----------------------------------------------------------------------------
package hbc_pkg;

	localparam int COORD_W    = 16;
	localparam int TAN_W      = COORD_W + 3;
	localparam int COEF_W     = COORD_W + 6;
	localparam int CNT_W      = 7;
	localparam int MAX_POINTS = 64;
	localparam int N_W        = $clog2(MAX_POINTS);
	localparam int N2_W       = 2 * N_W;
	localparam int N3_W       = 3 * N_W;
	localparam int D_W        = N3_W + 1;
	localparam int ACC_W      = 48;
	localparam int DIV_STEPS  = ACC_W;
	localparam int DCNT_W     = $clog2(DIV_STEPS);
	localparam int OUT_W      = 18;
	localparam int REG_W      = 24;
	localparam int IDX_W      = 2;

	localparam logic [IDX_W-1:0] REG_POINT_COUNT = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_PIXEL_COLOR = IDX_W'(1);

	localparam logic [CNT_W-1:0]  POINT_COUNT_RST = CNT_W'(64);
	localparam logic [CNT_W-1:0]  COUNT_MAX       = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0]  COUNT_MIN       = CNT_W'(2);
	localparam logic [DCNT_W-1:0] DIV_LAST        = DCNT_W'(DIV_STEPS - 1);

	localparam logic [ACC_W-1:0] MAG_POS = ACC_W'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [ACC_W-1:0] MAG_NEG = ACC_W'(64'd1 << (OUT_W - 1));
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Horner step selector
	typedef enum logic [1:0] {
		HS_FIRST = 2'd0,
		HS_MID   = 2'd1,
		HS_LAST  = 2'd2
	} horn_sel_t;

	typedef struct packed {
		logic             load;
		logic             prep0;
		logic             prep1;
		logic             prep2;
		logic             horn;
		horn_sel_t        horn_sel;
		logic             div_init;
		logic             div_step;
		logic [N_W-1:0]   n;
		logic [N_W-1:0]   k;
	} hbc_cmd_t;

endpackage

### hdl/hbc_curve_if.sv
// ----------------------------------------------------------------------------
// hbc_curve_if
// Curve request channel: kind and four coordinate pairs.
// ----------------------------------------------------------------------------
interface hbc_curve_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic signed [hbc_pkg::COORD_W-1:0] first_x;
	logic signed [hbc_pkg::COORD_W-1:0] first_y;
	logic signed [hbc_pkg::COORD_W-1:0] second_x;
	logic signed [hbc_pkg::COORD_W-1:0] second_y;
	logic signed [hbc_pkg::COORD_W-1:0] third_x;
	logic signed [hbc_pkg::COORD_W-1:0] third_y;
	logic signed [hbc_pkg::COORD_W-1:0] fourth_x;
	logic signed [hbc_pkg::COORD_W-1:0] fourth_y;

	modport source (output valid, action, first_x, first_y, second_x, second_y,
		third_x, third_y, fourth_x, fourth_y, input ready);
	modport sink (input valid, action, first_x, first_y, second_x, second_y,
		third_x, third_y, fourth_x, fourth_y, output ready);
endinterface

### hdl/hbc_point_if.sv
// ----------------------------------------------------------------------------
// hbc_point_if
// Pixel point channel: rounded coordinates and end-of-curve flag.
// ----------------------------------------------------------------------------
interface hbc_point_if;
	logic                             valid;
	logic                             ready;
	logic signed [hbc_pkg::OUT_W-1:0] pixel_x;
	logic signed [hbc_pkg::OUT_W-1:0] pixel_y;
	logic                             last_point;

	modport source (output valid, pixel_x, pixel_y, last_point, input ready);
	modport sink (input valid, pixel_x, pixel_y, last_point, output ready);
endinterface

### hdl/hbc_lane.sv
// ----------------------------------------------------------------------------
// hbc_lane
// One axis: cubic coefficients, Horner evaluation and rounding divider.
// ----------------------------------------------------------------------------
module hbc_lane (
	input  logic                               clk,
	input  hbc_pkg::hbc_cmd_t                  cmd,
	input  logic signed [hbc_pkg::TAN_W-1:0]   p0,
	input  logic signed [hbc_pkg::TAN_W-1:0]   t0,
	input  logic signed [hbc_pkg::TAN_W-1:0]   p1,
	input  logic signed [hbc_pkg::TAN_W-1:0]   t1,
	input  logic [hbc_pkg::N2_W-1:0]           n2,
	input  logic [hbc_pkg::N3_W-1:0]           n3,
	output logic signed [hbc_pkg::OUT_W-1:0]   pix
);

	logic signed [hbc_pkg::COEF_W-1:0] p0e, t0e, p1e, t1e;
	logic signed [hbc_pkg::COEF_W-1:0] c3_q, c2_q, c1_q, c0_q;
	logic signed [hbc_pkg::COEF_W+hbc_pkg::N_W:0]  a2_p;
	logic signed [hbc_pkg::COEF_W+hbc_pkg::N2_W:0] a1_p;
	logic signed [hbc_pkg::COEF_W+hbc_pkg::N3_W:0] a0_p;
	logic signed [hbc_pkg::ACC_W-1:0] a2_q, a1_q, a0_q, acc_q;
	logic signed [hbc_pkg::ACC_W-1:0] mul_a, mul_p, addend, num2;
	logic [hbc_pkg::ACC_W-1:0]        quo_q;
	logic [hbc_pkg::D_W-1:0]          rem_q, divisor;
	logic [hbc_pkg::D_W:0]            trial;
	logic                             neg_q;

	assign p0e = hbc_pkg::COEF_W'(p0);
	assign t0e = hbc_pkg::COEF_W'(t0);
	assign p1e = hbc_pkg::COEF_W'(p1);
	assign t1e = hbc_pkg::COEF_W'(t1);

	// scaled coefficients c2*n, c1*n^2, c0*n^3
	assign a2_p = c2_q * $signed({1'b0, cmd.n});
	assign a1_p = c1_q * $signed({1'b0, n2});
	assign a0_p = c0_q * $signed({1'b0, n3});

	// Horner multiplier input and addend
	always_comb begin
		unique case (cmd.horn_sel)
			hbc_pkg::HS_FIRST: begin
				mul_a  = hbc_pkg::ACC_W'(c3_q);
				addend = a2_q;
			end
			hbc_pkg::HS_MID: begin
				mul_a  = acc_q;
				addend = a1_q;
			end
			hbc_pkg::HS_LAST: begin
				mul_a  = acc_q;
				addend = a0_q;
			end
			default: begin
				mul_a  = acc_q;
				addend = a0_q;
			end
		endcase
	end

	assign mul_p   = mul_a * $signed({1'b0, cmd.k});
	assign num2    = (acc_q <<< 1) + $signed({{(hbc_pkg::ACC_W-hbc_pkg::N3_W){1'b0}}, n3});
	assign divisor = {n3, 1'b0};
	assign trial   = {rem_q, quo_q[hbc_pkg::ACC_W-1]};

	// coefficient load, scaling, Horner and restoring divide
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c3_q <= (p0e <<< 1) + t0e - (p1e <<< 1) + t1e;
			c2_q <= (p1e + (p1e <<< 1)) - (p0e + (p0e <<< 1)) - (t0e <<< 1) - t1e;
			c1_q <= t0e;
			c0_q <= p0e;
		end
		if (cmd.prep1) begin
			a2_q <= hbc_pkg::ACC_W'(a2_p);
			a1_q <= hbc_pkg::ACC_W'(a1_p);
		end
		if (cmd.prep2) begin
			a0_q <= hbc_pkg::ACC_W'(a0_p);
		end
		if (cmd.horn) begin
			acc_q <= mul_p + addend;
		end
		if (cmd.div_init) begin
			neg_q <= num2[hbc_pkg::ACC_W-1];
			quo_q <= num2[hbc_pkg::ACC_W-1] ? hbc_pkg::ACC_W'(-num2) : hbc_pkg::ACC_W'(num2);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= hbc_pkg::D_W'(trial - {1'b0, divisor});
				quo_q <= {quo_q[hbc_pkg::ACC_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[hbc_pkg::D_W-1:0];
				quo_q <= {quo_q[hbc_pkg::ACC_W-2:0], 1'b0};
			end
		end
	end

	// apply sign and saturate to the output range
	always_comb begin
		if (neg_q) begin
			pix = (quo_q > hbc_pkg::MAG_NEG) ? hbc_pkg::OUT_MIN
				: hbc_pkg::OUT_W'(-quo_q);
		end else begin
			pix = (quo_q > hbc_pkg::MAG_POS) ? hbc_pkg::OUT_MAX
				: hbc_pkg::OUT_W'(quo_q);
		end
	end

endmodule

### hdl/hbc_datapath.sv
// ----------------------------------------------------------------------------
// hbc_datapath
// Tangent forming, shared powers of n and the two axis lanes.
// ----------------------------------------------------------------------------
module hbc_datapath (
	input  logic                               clk,
	input  hbc_pkg::hbc_cmd_t                  cmd,
	input  logic                               action,
	input  logic signed [hbc_pkg::COORD_W-1:0] first_x,
	input  logic signed [hbc_pkg::COORD_W-1:0] first_y,
	input  logic signed [hbc_pkg::COORD_W-1:0] second_x,
	input  logic signed [hbc_pkg::COORD_W-1:0] second_y,
	input  logic signed [hbc_pkg::COORD_W-1:0] third_x,
	input  logic signed [hbc_pkg::COORD_W-1:0] third_y,
	input  logic signed [hbc_pkg::COORD_W-1:0] fourth_x,
	input  logic signed [hbc_pkg::COORD_W-1:0] fourth_y,
	output logic signed [hbc_pkg::OUT_W-1:0]   pixel_x,
	output logic signed [hbc_pkg::OUT_W-1:0]   pixel_y
);

	logic signed [hbc_pkg::TAN_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	logic signed [hbc_pkg::TAN_W-1:0] bez_t0x, bez_t0y, bez_t1x, bez_t1y;
	logic signed [hbc_pkg::TAN_W-1:0] p1x, p1y, t0x, t0y, t1x, t1y;
	logic [hbc_pkg::N2_W-1:0] n2_q;
	logic [hbc_pkg::N3_W-1:0] n3_q;

	assign ax = hbc_pkg::TAN_W'(first_x);
	assign ay = hbc_pkg::TAN_W'(first_y);
	assign bx = hbc_pkg::TAN_W'(second_x);
	assign by = hbc_pkg::TAN_W'(second_y);
	assign cx = hbc_pkg::TAN_W'(third_x);
	assign cy = hbc_pkg::TAN_W'(third_y);
	assign dx = hbc_pkg::TAN_W'(fourth_x);
	assign dy = hbc_pkg::TAN_W'(fourth_y);

	// Bezier tangents 3*(P1-P0) and 3*(P3-P2)
	assign bez_t0x = ((bx - ax) <<< 1) + (bx - ax);
	assign bez_t0y = ((by - ay) <<< 1) + (by - ay);
	assign bez_t1x = ((dx - cx) <<< 1) + (dx - cx);
	assign bez_t1y = ((dy - cy) <<< 1) + (dy - cy);

	// pick Hermite or Bezier operands
	assign t0x = action ? bez_t0x : bx;
	assign t0y = action ? bez_t0y : by;
	assign p1x = action ? dx : cx;
	assign p1y = action ? dy : cy;
	assign t1x = action ? bez_t1x : dx;
	assign t1y = action ? bez_t1y : dy;

	// powers of n for the common denominator
	always_ff @(posedge clk) begin
		if (cmd.prep0) begin
			n2_q <= cmd.n * cmd.n;
		end
		if (cmd.prep1) begin
			n3_q <= n2_q * cmd.n;
		end
	end

	hbc_lane u_lane_x (
		.clk (clk),
		.cmd (cmd),
		.p0  (ax),
		.t0  (t0x),
		.p1  (p1x),
		.t1  (t1x),
		.n2  (n2_q),
		.n3  (n3_q),
		.pix (pixel_x)
	);

	hbc_lane u_lane_y (
		.clk (clk),
		.cmd (cmd),
		.p0  (ay),
		.t0  (t0y),
		.p1  (p1y),
		.t1  (t1y),
		.n2  (n2_q),
		.n3  (n3_q),
		.pix (pixel_y)
	);

endmodule

### hdl/hbc_ctrl.sv
// ----------------------------------------------------------------------------
// hbc_ctrl
// Sequencer: per-curve setup, per-point Horner, divide and output handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  logic [hbc_pkg::CNT_W-1:0]  point_count,
	output hbc_pkg::hbc_cmd_t          cmd,
	output logic                       last_point
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PREP0 = 8'b0000_0010,
		ST_PREP1 = 8'b0000_0100,
		ST_PREP2 = 8'b0000_1000,
		ST_HORN  = 8'b0001_0000,
		ST_DINIT = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t                      state_q;
	hbc_pkg::horn_sel_t          hs_q;
	logic [hbc_pkg::N_W-1:0]     n_q, k_q;
	logic [hbc_pkg::DCNT_W-1:0]  dcnt_q;
	logic [hbc_pkg::CNT_W-1:0]   count;
	logic                        accept;

	// clamp the count to the supported maximum
	assign count  = (point_count > hbc_pkg::COUNT_MAX) ? hbc_pkg::COUNT_MAX : point_count;
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = (state_q == ST_OUT);
	assign last_point = (k_q == n_q);

	// drive datapath commands
	always_comb begin
		cmd.load     = accept;
		cmd.prep0    = (state_q == ST_PREP0);
		cmd.prep1    = (state_q == ST_PREP1);
		cmd.prep2    = (state_q == ST_PREP2);
		cmd.horn     = (state_q == ST_HORN);
		cmd.horn_sel = hs_q;
		cmd.div_init = (state_q == ST_DINIT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.n        = n_q;
		cmd.k        = k_q;
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hs_q    <= hbc_pkg::HS_FIRST;
			n_q     <= '0;
			k_q     <= '0;
			dcnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && count >= hbc_pkg::COUNT_MIN) begin
						n_q     <= hbc_pkg::N_W'(count - 1'b1);
						k_q     <= '0;
						state_q <= ST_PREP0;
					end
				end
				ST_PREP0: state_q <= ST_PREP1;
				ST_PREP1: state_q <= ST_PREP2;
				ST_PREP2: begin
					hs_q    <= hbc_pkg::HS_FIRST;
					state_q <= ST_HORN;
				end
				ST_HORN: begin
					unique case (hs_q)
						hbc_pkg::HS_FIRST: hs_q <= hbc_pkg::HS_MID;
						hbc_pkg::HS_MID:   hs_q <= hbc_pkg::HS_LAST;
						default:           state_q <= ST_DINIT;
					endcase
				end
				ST_DINIT: begin
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == hbc_pkg::DIV_LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (last_point) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							hs_q    <= hbc_pkg::HS_FIRST;
							state_q <= ST_HORN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`HBC_ASSERT(a_k_in_range, out_valid |-> (k_q <= n_q))
	`HBC_ASSERT_NEXT(a_div_len, (state_q == ST_DIV && dcnt_q == hbc_pkg::DIV_LAST), out_valid)
	`HBC_ASSERT_NEXT(a_stall_hold, (out_valid && !out_ready), (out_valid && $stable(k_q)))
	`HBC_ASSERT_NEXT(a_run_end, (out_valid && out_ready && last_point), in_ready)

endmodule

### hdl/hermite_bezier_curve_points.sv
// ----------------------------------------------------------------------------
// hermite_bezier_curve_points
// Cubic Hermite / Bezier curve rasteriser with exact rational rounding.
// ----------------------------------------------------------------------------
// Usage:
//  curve (sink): one request per curve, Hermite (action 0) or Bezier (1).
//  point (source): point_count points per curve, last_point on the final one.
//  cfg port: index 0 point_count (clamped to 64, below two emits nothing),
//  index 1 pixel_color (held for the pixel writer). Write only while idle.
//  Flow: a request is taken only when the previous run has ended. Setup
//  forms the powers of n and the scaled coefficients, then each point runs
//  the Horner steps, a divider load and the bit-serial restoring divider,
//  then it is shown. The divider makes one quotient bit per cycle.
//  A stalled receiver holds the point steady and pauses the run.
//  Reset returns the sequencer to idle and point_count to 64.
// ----------------------------------------------------------------------------
module hermite_bezier_curve_points (
	input  logic                         clk,
	input  logic                         arst_n,
	hbc_curve_if.sink                    curve,
	hbc_point_if.source                  point,
	input  logic                         cfg_we,
	input  logic [hbc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [hbc_pkg::REG_W-1:0]    cfg_wdata
);

	logic [hbc_pkg::CNT_W-1:0] point_count_q;
	logic [hbc_pkg::REG_W-1:0] pixel_color_q;
	hbc_pkg::hbc_cmd_t         cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= hbc_pkg::POINT_COUNT_RST;
			pixel_color_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbc_pkg::REG_POINT_COUNT: point_count_q <= cfg_wdata[hbc_pkg::CNT_W-1:0];
				hbc_pkg::REG_PIXEL_COLOR: pixel_color_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hbc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (curve.valid),
		.in_ready    (curve.ready),
		.out_valid   (point.valid),
		.out_ready   (point.ready),
		.point_count (point_count_q),
		.cmd         (cmd),
		.last_point  (point.last_point)
	);

	hbc_datapath u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.action   (curve.action),
		.first_x  (curve.first_x),
		.first_y  (curve.first_y),
		.second_x (curve.second_x),
		.second_y (curve.second_y),
		.third_x  (curve.third_x),
		.third_y  (curve.third_y),
		.fourth_x (curve.fourth_x),
		.fourth_y (curve.fourth_y),
		.pixel_x  (point.pixel_x),
		.pixel_y  (point.pixel_y)
	);

endmodule

### bench/curve_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curve_scoreboard
// Predicts the pixel points of each accepted curve request and checks the
// points that leave the rasteriser against them, oldest first.
// ----------------------------------------------------------------------------
class curve_scoreboard;

	typedef struct {
		logic signed [17:0] px;
		logic signed [17:0] py;
		logic               last;
	} point_t;

	point_t    pending_points[$];
	int        mismatches;
	int        points_checked;
	logic [6:0] point_count;

	function new();
		pending_points = {};
		mismatches     = 0;
		points_checked = 0;
		point_count    = 7'd64;
	endfunction

	// Rounded, saturated value of one axis at step k of n
	function automatic logic signed [17:0] axis_value(longint c3, longint c2, longint c1,
			longint c0, longint k, longint n);
		longint d;
		longint num;
		longint r;
		d   = n * n * n;
		num = c3 * k * k * k + c2 * k * k * n + c1 * k * n * n + c0 * d;
		r   = (2 * num + d) / (2 * d);
		if (r > 131071)
			r = 131071;
		if (r < -131072)
			r = -131072;
		return r[17:0];
	endfunction

	// Note an accepted request and queue the points it causes
	function void note_request(logic action, longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint dx, longint dy);
		longint p0x, t0x, p1x, t1x, p0y, t0y, p1y, t1y;
		longint cnt;
		longint n;
		point_t p;
		p0x = ax;
		p0y = ay;
		if (action) begin
			t0x = 3 * (bx - ax);
			t0y = 3 * (by - ay);
			p1x = dx;
			p1y = dy;
			t1x = 3 * (dx - cx);
			t1y = 3 * (dy - cy);
		end else begin
			t0x = bx;
			t0y = by;
			p1x = cx;
			p1y = cy;
			t1x = dx;
			t1y = dy;
		end
		cnt = point_count;
		if (cnt > 64)
			cnt = 64;
		if (cnt < 2)
			return;
		n = cnt - 1;
		for (longint k = 0; k < cnt; k++) begin
			p.px = axis_value(2*p0x + t0x - 2*p1x + t1x, -3*p0x - 2*t0x + 3*p1x - t1x,
				t0x, p0x, k, n);
			p.py = axis_value(2*p0y + t0y - 2*p1y + t1y, -3*p0y - 2*t0y + 3*p1y - t1y,
				t0y, p0y, k, n);
			p.last = (k == cnt - 1);
			pending_points.push_back(p);
		end
	endfunction

	task report(string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Check one emitted point against the oldest prediction
	task check_point(logic signed [17:0] px, logic signed [17:0] py, logic last);
		point_t e;
		if (pending_points.size() == 0) begin
			report($sformatf("unexpected point (%0d,%0d)", px, py));
			return;
		end
		e = pending_points.pop_front();
		points_checked++;
		if (px !== e.px)
			report($sformatf("pixel_x %0d, predicted %0d", px, e.px));
		if (py !== e.py)
			report($sformatf("pixel_y %0d, predicted %0d", py, e.py));
		if (last !== e.last)
			report($sformatf("last_point %0b, predicted %0b", last, e.last));
	endtask

endclass

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives curve requests of both kinds through the rasteriser under several
// point counts and handshake idling patterns, and checks every point.
// ----------------------------------------------------------------------------
module tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [hbc_pkg::IDX_W-1:0] cfg_index;
	logic [hbc_pkg::REG_W-1:0] cfg_wdata;

	hbc_curve_if curve ();
	hbc_point_if point ();

	hermite_bezier_curve_points dut (
		.clk(clk), .arst_n(arst_n), .curve(curve), .point(point),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	curve_scoreboard board = new();
	int send_idle_pct;
	int recv_stall_pct;
	int requests_sent;
	int phases_run;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Receiver: stall at random, check on each accepted point
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point.ready <= 1'b0;
		end else begin
			if (point.valid && point.ready)
				board.check_point(point.pixel_x, point.pixel_y, point.last_point);
			point.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Write one register, then leave the port quiet
	task write_reg(logic [hbc_pkg::IDX_W-1:0] idx, logic [hbc_pkg::REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == hbc_pkg::REG_POINT_COUNT)
			board.point_count = val[6:0];
		@(posedge clk);
	endtask

	// Hold a request until accepted, with random idle cycles beforehand
	task send_request(logic act, logic [15:0] v [8]);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		curve.valid    <= 1'b1;
		curve.action   <= act;
		curve.first_x  <= v[0];
		curve.first_y  <= v[1];
		curve.second_x <= v[2];
		curve.second_y <= v[3];
		curve.third_x  <= v[4];
		curve.third_y  <= v[5];
		curve.fourth_x <= v[6];
		curve.fourth_y <= v[7];
		do
			@(posedge clk);
		while (!curve.ready);
		board.note_request(act, $signed(v[0]), $signed(v[1]), $signed(v[2]),
			$signed(v[3]), $signed(v[4]), $signed(v[5]), $signed(v[6]), $signed(v[7]));
		requests_sent++;
		curve.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every predicted point has arrived, then leave the rasteriser idle
	task drain();
		while (board.pending_points.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(400)) - 16'd200;
			default: return 16'($urandom);
		endcase
	endfunction

	task random_batch(int count);
		logic [15:0] v [8];
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(3);
			for (int j = 0; j < 8; j++)
				v[j] = ($urandom_range(9) == 0) ? rand_coord($urandom_range(1)) :
					rand_coord(mode < 2 ? 2 : 3);
			send_request(1'($urandom_range(1)), v);
		end
	endtask

	initial begin
		#50000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [15:0] v [8];
		logic [6:0] counts [7];
		counts = '{7'd2, 7'd0, 7'd1, 7'd127, 7'd3, 7'd64, 7'd5};
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		curve.valid  = 1'b0;
		curve.action = 1'b0;
		curve.first_x = '0; curve.first_y = '0; curve.second_x = '0; curve.second_y = '0;
		curve.third_x = '0; curve.third_y = '0; curve.fourth_x = '0; curve.fourth_y = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		requests_sent  = 0;
		phases_run     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of each field, both kinds, reset count of 64
		write_reg(hbc_pkg::REG_PIXEL_COLOR, 24'hFFFFFF);
		for (int m = 0; m < 4; m++) begin
			for (int j = 0; j < 8; j++)
				v[j] = (m == 0) ? 16'h8000 : (m == 1) ? 16'h7FFF :
					(j[0] ? 16'h8000 : 16'h7FFF);
			send_request(m[0], v);
			send_request(!m[0], v);
		end
		drain();

		// Directed: saturating, tiny and empty counts
		foreach (counts[c]) begin
			write_reg(hbc_pkg::REG_POINT_COUNT, {17'd0, counts[c]});
			for (int j = 0; j < 8; j++)
				v[j] = rand_coord(3);
			send_request(c[0], v);
			drain();
		end
		write_reg(hbc_pkg::REG_PIXEL_COLOR, 24'h000000);

		// Random phases across counts and idling patterns
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			write_reg(hbc_pkg::REG_POINT_COUNT,
				(p == 7) ? 24'd64 : 24'($urandom_range(12)));
			write_reg(hbc_pkg::REG_PIXEL_COLOR, 24'($urandom));
			random_batch(20);
			drain();
			random_batch(20);
			drain();
			phases_run++;
		end

		$display("Sent %0d curve requests over %0d idling phases; %0d points checked.",
			requests_sent, phases_run, board.points_checked);
		if (board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/hbc_pkg.sv
hdl/hbc_curve_if.sv
hdl/hbc_point_if.sv
hdl/hbc_lane.sv
hdl/hbc_datapath.sv
hdl/hbc_ctrl.sv
hdl/hermite_bezier_curve_points.sv
bench/curve_scoreboard.sv
bench/tb.sv
